// ===== design/trcq_pkg.sv =====
// Shared types, codes and constants for the tick release command queue.
// No dependencies; every other design file refers to this package by scoped names.
package trcq_pkg;

	// Default sizes handed to the top level parameters.
	localparam int DEF_QUEUE_DEPTH = 32;
	localparam int DEF_MAX_SEATS   = 8;
	localparam int DEF_MAX_UNITS   = 32;

	// Fixed field widths.
	localparam int CNT_W   = 6;
	localparam int SEAT_W  = 4;
	localparam int TYPE_W  = 8;
	localparam int UNITS_W = 6;
	localparam int TICK_W  = 32;
	localparam int PAY_W   = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 32;

	// Request command codes.
	localparam logic [1:0] CMD_SUBMIT_REL = 2'd0;
	localparam logic [1:0] CMD_SUBMIT_ABS = 2'd1;
	localparam logic [1:0] CMD_RUN        = 2'd2;

	// Result kinds.
	localparam logic [1:0] KIND_SUBMIT  = 2'd0;
	localparam logic [1:0] KIND_RELEASE = 2'd1;
	localparam logic [1:0] KIND_DONE    = 2'd2;

	// Submit status codes.
	localparam logic [2:0] STS_OK        = 3'd0;
	localparam logic [2:0] STS_BAD_TYPE  = 3'd1;
	localparam logic [2:0] STS_BAD_UNITS = 3'd2;
	localparam logic [2:0] STS_BAD_SEAT  = 3'd3;
	localparam logic [2:0] STS_FULL      = 3'd4;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_DELAY_TICKS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TYPE_LIMIT  = 1'd1;

	localparam logic [TYPE_W-1:0] TYPE_LIMIT_RESET = 8'd16;

	// One stored command.
	typedef struct packed {
		logic [SEAT_W-1:0]  seat;
		logic [TYPE_W-1:0]  ctype;
		logic [UNITS_W-1:0] units;
		logic [TICK_W-1:0]  tick;
		logic [TICK_W-1:0]  order;
		logic [PAY_W-1:0]   payload;
	} trcq_entry_t;

	// Controls from the sequencer to the match unit.
	typedef struct packed {
		logic              clear;
		logic              cand_vld;
		logic [SEAT_W-1:0] seat;
		logic [TICK_W-1:0] run_tick;
	} trcq_match_ctl_t;

	// Best candidate found by the match unit so far.
	typedef struct packed {
		logic        found;
		trcq_entry_t entry;
	} trcq_best_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FIND,
		ST_SUBMIT_OUT,
		ST_SCAN,
		ST_DECIDE,
		ST_RELEASE_OUT,
		ST_DONE_OUT
	} trcq_state_t;

endpackage

// ===== design/trcq_if.sv =====
// Request and result channel interfaces with valid/ready handshakes.
// Depends on trcq_pkg for field widths.
interface trcq_req_if;
	logic                          valid;
	logic                          ready;
	logic [1:0]                    cmd;
	logic [7:0]                    seat;
	logic [trcq_pkg::TYPE_W-1:0]   command_type;
	logic [7:0]                    num_units;
	logic [trcq_pkg::TICK_W-1:0]   target_tick;
	logic [trcq_pkg::PAY_W-1:0]    payload_ref;

	modport source (output valid, cmd, seat, command_type, num_units, target_tick,
		payload_ref, input ready);
	modport sink (input valid, cmd, seat, command_type, num_units, target_tick,
		payload_ref, output ready);
endinterface

interface trcq_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [1:0]                    kind;
	logic [2:0]                    status;
	logic [trcq_pkg::SEAT_W-1:0]   out_seat;
	logic [trcq_pkg::TYPE_W-1:0]   out_type;
	logic [trcq_pkg::UNITS_W-1:0]  out_units;
	logic [trcq_pkg::TICK_W-1:0]   release_tick;
	logic [trcq_pkg::PAY_W-1:0]    out_payload;
	logic [trcq_pkg::CNT_W-1:0]    pending;
	logic [31:0]                   applied_total;
	logic [trcq_pkg::TICK_W-1:0]   now_tick;
	logic                          last;

	modport source (output valid, kind, status, out_seat, out_type, out_units, release_tick,
		out_payload, pending, applied_total, now_tick, last, input ready);
	modport sink (input valid, kind, status, out_seat, out_type, out_units, release_tick,
		out_payload, pending, applied_total, now_tick, last, output ready);
endinterface

// ===== design/tick_release_command_queue_core.sv =====
// Top level of the tick release command queue: sequencer, counters and result register.
// Depends on trcq_pkg, trcq_if, trcq_slot_ram and trcq_match_unit.

// A submit takes the lowest free slot found by stepping through the valid bits one slot a
// cycle, while a rejected submit goes straight to its result. A run goes seat by seat
// through one compare unit that reads the slot memory one entry a cycle: each seat needs
// one pass over the memory per released command plus one empty pass. The block takes
// no new request while one is at work; a finished result waits in the output register, and
// the block stalls only when it needs that register again before it has been taken.
module tick_release_command_queue_core #(
	parameter int QUEUE_DEPTH = trcq_pkg::DEF_QUEUE_DEPTH,
	parameter int MAX_SEATS   = trcq_pkg::DEF_MAX_SEATS,
	parameter int MAX_UNITS   = trcq_pkg::DEF_MAX_UNITS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [trcq_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [trcq_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	trcq_req_if.sink                           req,
	trcq_rsp_if.source                         rsp
);

	localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);
	localparam logic [trcq_pkg::CNT_W-1:0] DEPTH_CNT = trcq_pkg::CNT_W'(QUEUE_DEPTH);
	localparam logic [trcq_pkg::SEAT_W-1:0] LAST_SEAT = trcq_pkg::SEAT_W'(MAX_SEATS);
	localparam logic [7:0] SEAT_LIMIT  = 8'(MAX_SEATS);
	localparam logic [7:0] UNITS_LIMIT = 8'(MAX_UNITS);

	trcq_pkg::trcq_state_t state_q, state_d;

	// Configuration registers.
	logic [trcq_pkg::TICK_W-1:0] delay_q;
	logic [trcq_pkg::TYPE_W-1:0] type_limit_q;

	// Queue state.
	logic [QUEUE_DEPTH-1:0]       slot_valid_q;
	logic [trcq_pkg::CNT_W-1:0]   held_q;
	logic [31:0]                  arrival_q;
	logic [trcq_pkg::TICK_W-1:0]  tick_q;
	logic [31:0]                  released_q;

	// Sequencer working registers.
	logic [trcq_pkg::SEAT_W-1:0]  seat_q;
	logic [IDX_W-1:0]             scan_idx_q;
	logic                         issue_done_q;
	logic                         rd_vld_s1;
	logic [IDX_W-1:0]             rd_idx_s1;
	logic [2:0]                   status_q;
	logic [trcq_pkg::TICK_W-1:0]  rtick_q;
	trcq_pkg::trcq_entry_t        new_entry_q;

	// Result register.
	logic                         rsp_valid_q;
	logic [1:0]                   kind_q;
	logic [2:0]                   rsp_status_q;
	logic [trcq_pkg::SEAT_W-1:0]  out_seat_q;
	logic [trcq_pkg::TYPE_W-1:0]  out_type_q;
	logic [trcq_pkg::UNITS_W-1:0] out_units_q;
	logic [trcq_pkg::TICK_W-1:0]  release_tick_q;
	logic [trcq_pkg::PAY_W-1:0]   out_payload_q;
	logic [trcq_pkg::CNT_W-1:0]   pending_q;
	logic [31:0]                  applied_q;
	logic [trcq_pkg::TICK_W-1:0]  now_tick_q;
	logic                         last_q;

	// Sequencer strobes.
	logic req_acc, is_submit, run_start, start_scan, next_seat, find_write, scan_issue;
	logic load_submit, load_release, load_done, out_free;
	logic [2:0]                  chk_status;
	logic [trcq_pkg::TICK_W-1:0] chk_rtick;

	trcq_pkg::trcq_entry_t     ram_wdata, ram_rdata;
	trcq_pkg::trcq_match_ctl_t match_ctl;
	trcq_pkg::trcq_best_t      best;
	logic [IDX_W-1:0]          best_idx;

	assign req_acc   = req.valid && req.ready;
	assign is_submit = (req.cmd == trcq_pkg::CMD_SUBMIT_REL)
		|| (req.cmd == trcq_pkg::CMD_SUBMIT_ABS);
	assign out_free  = !rsp_valid_q || rsp.ready;

	// Submit checks in priority order, and the release tick a submit would get.
	always_comb begin
		priority if (req.command_type >= type_limit_q) begin
			chk_status = trcq_pkg::STS_BAD_TYPE;
		end else if (req.num_units > UNITS_LIMIT) begin
			chk_status = trcq_pkg::STS_BAD_UNITS;
		end else if ((req.seat == 8'd0) || (req.seat > SEAT_LIMIT)) begin
			chk_status = trcq_pkg::STS_BAD_SEAT;
		end else if (held_q >= DEPTH_CNT) begin
			chk_status = trcq_pkg::STS_FULL;
		end else begin
			chk_status = trcq_pkg::STS_OK;
		end
		if (req.cmd == trcq_pkg::CMD_SUBMIT_REL) begin
			chk_rtick = tick_q + delay_q;
		end else if (req.target_tick < tick_q) begin
			chk_rtick = tick_q;
		end else begin
			chk_rtick = req.target_tick;
		end
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= trcq_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and sequencer strobes.
	always_comb begin
		state_d      = state_q;
		req.ready    = 1'b0;
		run_start    = 1'b0;
		start_scan   = 1'b0;
		next_seat    = 1'b0;
		find_write   = 1'b0;
		scan_issue   = 1'b0;
		load_submit  = 1'b0;
		load_release = 1'b0;
		load_done    = 1'b0;
		unique case (state_q)
			trcq_pkg::ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					if (is_submit) begin
						state_d = (chk_status == trcq_pkg::STS_OK) ? trcq_pkg::ST_FIND
							: trcq_pkg::ST_SUBMIT_OUT;
					end else if (req.cmd == trcq_pkg::CMD_RUN) begin
						run_start  = 1'b1;
						start_scan = 1'b1;
						state_d    = trcq_pkg::ST_SCAN;
					end
				end
			end
			trcq_pkg::ST_FIND: begin
				if (!slot_valid_q[scan_idx_q]) begin
					find_write = 1'b1;
					state_d    = trcq_pkg::ST_SUBMIT_OUT;
				end
			end
			trcq_pkg::ST_SUBMIT_OUT: begin
				if (out_free) begin
					load_submit = 1'b1;
					state_d     = trcq_pkg::ST_IDLE;
				end
			end
			trcq_pkg::ST_SCAN: begin
				scan_issue = !issue_done_q;
				if (rd_vld_s1 && (rd_idx_s1 == LAST_IDX)) begin
					state_d = trcq_pkg::ST_DECIDE;
				end
			end
			trcq_pkg::ST_DECIDE: begin
				if (best.found) begin
					state_d = trcq_pkg::ST_RELEASE_OUT;
				end else if (seat_q == LAST_SEAT) begin
					state_d = trcq_pkg::ST_DONE_OUT;
				end else begin
					next_seat  = 1'b1;
					start_scan = 1'b1;
					state_d    = trcq_pkg::ST_SCAN;
				end
			end
			trcq_pkg::ST_RELEASE_OUT: begin
				if (out_free) begin
					load_release = 1'b1;
					start_scan   = 1'b1;
					state_d      = trcq_pkg::ST_SCAN;
				end
			end
			trcq_pkg::ST_DONE_OUT: begin
				if (out_free) begin
					load_done = 1'b1;
					state_d   = trcq_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = trcq_pkg::ST_IDLE;
			end
		endcase
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q      <= '0;
			type_limit_q <= trcq_pkg::TYPE_LIMIT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				trcq_pkg::REG_DELAY_TICKS: delay_q <= cfg_wdata;
				trcq_pkg::REG_TYPE_LIMIT:  type_limit_q <= cfg_wdata[trcq_pkg::TYPE_W-1:0];
				default: ;
			endcase
		end
	end

	// Queue counters and valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q <= '0;
			held_q       <= '0;
			arrival_q    <= '0;
			tick_q       <= '0;
			released_q   <= '0;
		end else begin
			if (find_write) begin
				slot_valid_q[scan_idx_q] <= 1'b1;
				held_q    <= held_q + 1'b1;
				arrival_q <= arrival_q + 1'b1;
			end
			if (load_release) begin
				slot_valid_q[best_idx] <= 1'b0;
				held_q     <= held_q - 1'b1;
				released_q <= released_q + 1'b1;
			end
			if (load_done) begin
				tick_q <= tick_q + 1'b1;
			end
		end
	end

	// Scan sequencing: seat under test, slot index and read pipeline valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seat_q       <= '0;
			scan_idx_q   <= '0;
			issue_done_q <= 1'b0;
			rd_vld_s1    <= 1'b0;
		end else begin
			rd_vld_s1 <= scan_issue;
			if (run_start) begin
				seat_q <= trcq_pkg::SEAT_W'(1);
			end else if (next_seat) begin
				seat_q <= seat_q + 1'b1;
			end
			if (req_acc || start_scan) begin
				scan_idx_q   <= '0;
				issue_done_q <= 1'b0;
			end else if (state_q == trcq_pkg::ST_FIND) begin
				scan_idx_q <= scan_idx_q + 1'b1;
			end else if (scan_issue) begin
				if (scan_idx_q == LAST_IDX) begin
					issue_done_q <= 1'b1;
				end else begin
					scan_idx_q <= scan_idx_q + 1'b1;
				end
			end
		end
	end

	// Request payload captured at acceptance.
	always_ff @(posedge clk) begin
		rd_idx_s1 <= scan_idx_q;
		if (req_acc) begin
			status_q            <= chk_status;
			rtick_q             <= (chk_status == trcq_pkg::STS_OK) ? chk_rtick : '0;
			new_entry_q.seat    <= req.seat[trcq_pkg::SEAT_W-1:0];
			new_entry_q.ctype   <= req.command_type;
			new_entry_q.units   <= req.num_units[trcq_pkg::UNITS_W-1:0];
			new_entry_q.tick    <= chk_rtick;
			new_entry_q.order   <= '0;
			new_entry_q.payload <= req.payload_ref;
		end
	end

	// The new entry takes its arrival number when it is written.
	always_comb begin
		ram_wdata       = new_entry_q;
		ram_wdata.order = arrival_q;
	end

	trcq_slot_ram #(
		.DEPTH (QUEUE_DEPTH),
		.IDX_W (IDX_W)
	) u_slot_ram (
		.clk   (clk),
		.we    (find_write),
		.waddr (scan_idx_q),
		.wdata (ram_wdata),
		.re    (scan_issue),
		.raddr (scan_idx_q),
		.rdata (ram_rdata)
	);

	assign match_ctl.clear    = start_scan;
	assign match_ctl.cand_vld = rd_vld_s1 && slot_valid_q[rd_idx_s1];
	assign match_ctl.seat     = seat_q;
	assign match_ctl.run_tick = tick_q;

	trcq_match_unit #(
		.IDX_W (IDX_W)
	) u_match (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (match_ctl),
		.cand_idx (rd_idx_s1),
		.cand     (ram_rdata),
		.best     (best),
		.best_idx (best_idx)
	);

	// Result register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load_submit || load_release || load_done) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (load_submit) begin
			kind_q         <= trcq_pkg::KIND_SUBMIT;
			rsp_status_q   <= status_q;
			out_seat_q     <= '0;
			out_type_q     <= '0;
			out_units_q    <= '0;
			release_tick_q <= rtick_q;
			out_payload_q  <= '0;
			pending_q      <= held_q;
			applied_q      <= released_q;
			now_tick_q     <= tick_q;
			last_q         <= 1'b1;
		end else if (load_release) begin
			kind_q         <= trcq_pkg::KIND_RELEASE;
			rsp_status_q   <= trcq_pkg::STS_OK;
			out_seat_q     <= best.entry.seat;
			out_type_q     <= best.entry.ctype;
			out_units_q    <= best.entry.units;
			release_tick_q <= tick_q;
			out_payload_q  <= best.entry.payload;
			pending_q      <= held_q - 1'b1;
			applied_q      <= released_q + 1'b1;
			now_tick_q     <= tick_q;
			last_q         <= 1'b0;
		end else if (load_done) begin
			kind_q         <= trcq_pkg::KIND_DONE;
			rsp_status_q   <= trcq_pkg::STS_OK;
			out_seat_q     <= '0;
			out_type_q     <= '0;
			out_units_q    <= '0;
			release_tick_q <= tick_q;
			out_payload_q  <= '0;
			pending_q      <= held_q;
			applied_q      <= released_q;
			now_tick_q     <= tick_q + 1'b1;
			last_q         <= 1'b1;
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.kind          = kind_q;
	assign rsp.status        = rsp_status_q;
	assign rsp.out_seat      = out_seat_q;
	assign rsp.out_type      = out_type_q;
	assign rsp.out_units     = out_units_q;
	assign rsp.release_tick  = release_tick_q;
	assign rsp.out_payload   = out_payload_q;
	assign rsp.pending       = pending_q;
	assign rsp.applied_total = applied_q;
	assign rsp.now_tick      = now_tick_q;
	assign rsp.last          = last_q;

`ifndef NO_ASSERTIONS
	// The held count always matches the number of occupied slots.
	a_held_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(slot_valid_q) == 32'(held_q))
		else $error("held count differs from occupied slots");

	// A free-slot search only starts when the queue has room.
	a_find_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == trcq_pkg::ST_FIND) |-> (held_q < DEPTH_CNT))
		else $error("free-slot search with a full queue");

	// The tick advances only together with a tick-done result.
	a_tick_with_done: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(tick_q) |-> (rsp_valid_q && (kind_q == trcq_pkg::KIND_DONE)))
		else $error("tick advanced without a tick-done result");

	// A release never targets an empty slot.
	a_release_valid_slot: assert property (@(posedge clk) disable iff (!arst_n)
		load_release |-> slot_valid_q[best_idx])
		else $error("release of an empty slot");
`endif

endmodule

// ===== design/trcq_slot_ram.sv =====
// Slot storage for queued commands: one write port, one registered read port.
// Depends on trcq_pkg for the entry type.
module trcq_slot_ram #(
	parameter int DEPTH = trcq_pkg::DEF_QUEUE_DEPTH,
	parameter int IDX_W = 5
) (
	input  logic                  clk,
	input  logic                  we,
	input  logic [IDX_W-1:0]      waddr,
	input  trcq_pkg::trcq_entry_t wdata,
	input  logic                  re,
	input  logic [IDX_W-1:0]      raddr,
	output trcq_pkg::trcq_entry_t rdata
);

	trcq_pkg::trcq_entry_t mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== design/trcq_match_unit.sv =====
// Compare unit that keeps the oldest due entry of one seat over a slot scan.
// Depends on trcq_pkg for the entry, control and result types.
module trcq_match_unit #(
	parameter int IDX_W = 5
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  trcq_pkg::trcq_match_ctl_t ctl,
	input  logic [IDX_W-1:0]          cand_idx,
	input  trcq_pkg::trcq_entry_t     cand,
	output trcq_pkg::trcq_best_t      best,
	output logic [IDX_W-1:0]          best_idx
);

	logic                  found_q;
	trcq_pkg::trcq_entry_t best_q;
	logic [IDX_W-1:0]      best_idx_q;
	logic                  hit;

	// A candidate wins when it is due for this seat and strictly older than the best so far,
	// so on equal arrival numbers the lower slot stays.
	always_comb begin
		hit = ctl.cand_vld && (cand.seat == ctl.seat) && (cand.tick == ctl.run_tick)
			&& (!found_q || (cand.order < best_q.order));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (ctl.clear) begin
			found_q <= 1'b0;
		end else if (hit) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!ctl.clear && hit) begin
			best_q     <= cand;
			best_idx_q <= cand_idx;
		end
	end

	assign best.found = found_q;
	assign best.entry = best_q;
	assign best_idx   = best_idx_q;

endmodule
